FILE: rtl/core/gcm_pkg.sv
// Package for the blended glyph color match block.
// Holds table depths, field widths, opcodes, register indexes and shared types.
// Used by gcm_lane and blended_glyph_color_match in rtl/core.
package gcm_pkg;

	localparam int BG_DEPTH = 16;
	localparam int FG_DEPTH = 16;
	localparam int GL_DEPTH = 256;
	localparam int BG_AW    = $clog2(BG_DEPTH);
	localparam int FG_AW    = $clog2(FG_DEPTH);
	localparam int GL_AW    = $clog2(GL_DEPTH);

	localparam int COLOR_W  = 24;
	localparam int GLYPH_W  = 24;
	localparam int CNT_W    = 12;
	localparam int Q_W      = 10;
	localparam int REM_W    = 28;
	localparam int ERR_W    = 21;
	localparam int BLEND_DIV = 80;

	localparam logic [1:0] OP_LOAD_BG = 2'd0;
	localparam logic [1:0] OP_LOAD_FG = 2'd1;
	localparam logic [1:0] OP_LOAD_GL = 2'd2;
	localparam logic [1:0] OP_MATCH   = 2'd3;

	localparam logic [1:0] REG_BG_COUNT = 2'd0;
	localparam logic [1:0] REG_FG_COUNT = 2'd1;
	localparam logic [1:0] REG_GL_COUNT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_SCALE,
		ST_DIV,
		ST_SQR,
		ST_CMP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic mul;
		logic scale;
		logic step;
	} lane_ctl_t;

endpackage

FILE: rtl/core/gcm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module gcm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/gcm_lane.sv
// One color channel of the blend: weighted sum, scale by 255 and an
// iterative restoring divide by 80*total, one quotient bit per step.
// Depends on gcm_pkg.
module gcm_lane import gcm_pkg::*; (
	input  logic             clk,
	input  lane_ctl_t        ctl,
	input  logic [7:0]       bg_ch,
	input  logic [7:0]       fg_ch,
	input  logic [CNT_W-1:0] lit,
	input  logic [CNT_W-1:0] total,
	output logic [Q_W-1:0]   y
);

	logic [CNT_W-1:0] lit_c;
	logic [19:0]      pa_s1, pb_s1;
	logic             zero_s1, zero_s2;
	logic [CNT_W-1:0] cell_s1;
	logic [20:0]      sum;
	logic [REM_W-1:0] rem_q, dsh_q;
	logic [Q_W-1:0]   quo_q;
	logic [18:0]      dvs;

	assign lit_c = (lit > total) ? total : lit;
	assign sum   = {1'b0, pa_s1} + {1'b0, pb_s1};
	assign dvs   = 19'(cell_s1) * 19'(BLEND_DIV);

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			pa_s1   <= 20'(bg_ch) * 20'(total - lit_c);
			pb_s1   <= 20'(fg_ch) * 20'(lit_c);
			zero_s1 <= (total == '0);
			cell_s1 <= total;
		end
		if (ctl.scale) begin
			rem_q   <= REM_W'({sum, 8'd0} - {8'd0, sum});
			dsh_q   <= REM_W'({dvs, 9'd0});
			quo_q   <= '0;
			zero_s2 <= zero_s1;
		end
		if (ctl.step) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[Q_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[Q_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign y = zero_s2 ? '0 : quo_q;

endmodule

FILE: rtl/core/blended_glyph_color_match.sv
// Top level of the blended glyph color match block.
// Holds the table RAMs, the combination sequencer and the best-match tracker.
// Depends on gcm_pkg, gcm_ram and gcm_lane.
//
// Input beats carry a load or a match (op in s_tuser). A load writes one
// table entry in the cycle it is accepted and gives no output beat. A match
// walks every background, foreground and glyph combination in order and
// gives one output beat: found in m_tuser, the best indices and error in
// m_tdata. Each combination passes through the RAM read, the products, the
// scale step, the 10-step divider, the squares and the compare; a match
// with an empty table skips the walk and gives an output beat with found
// clear. New beats are taken only when no match is running.
// The count registers are written through cfg_we/cfg_index/cfg_wdata.
// Reset clears the counts and the control state; the table contents stay
// undefined until loaded. A result held by a stalled receiver stays in the
// output register; loads are still accepted, and a following match finishes
// its walk and then waits for the output register to drain.
module blended_glyph_color_match import gcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // entry_index, red, green, blue, lit_pixels, cell_pixels
	input  logic [1:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // best_background, best_foreground, best_glyph, best_error, pad
	output logic        m_tuser,   // found
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_wdata
);

	logic [7:0]       entry_index, red, green, blue;
	logic [CNT_W-1:0] lit_pixels, cell_pixels;
	logic             accept;
	logic [4:0]       bg_cnt_q, fg_cnt_q;
	logic [8:0]       gl_cnt_q;
	logic [8:0]       nb, nf, ng;
	state_t           state_q, state_d;
	logic [BG_AW-1:0] b_q;
	logic [FG_AW-1:0] f_q;
	logic [GL_AW-1:0] g_q;
	logic [3:0]       step_q;
	logic [7:0]       px_q [3];
	logic [COLOR_W-1:0] bg_rd, fg_rd;
	logic [GLYPH_W-1:0] gl_rd;
	lane_ctl_t        lctl;
	logic [Q_W-1:0]   yv [3];
	logic [19:0]      sq_s1 [3];
	logic [ERR_W-1:0] err;
	logic             found_q;
	logic [BG_AW-1:0] best_b_q;
	logic [FG_AW-1:0] best_f_q;
	logic [GL_AW-1:0] best_g_q;
	logic [ERR_W-1:0] best_e_q;
	logic             last_g, last_f, last_b, empty, out_free;

	assign entry_index = s_tdata[7:0];
	assign red         = s_tdata[15:8];
	assign green       = s_tdata[23:16];
	assign blue        = s_tdata[31:24];
	assign lit_pixels  = s_tdata[43:32];
	assign cell_pixels = s_tdata[55:44];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_cnt_q <= '0;
			fg_cnt_q <= '0;
			gl_cnt_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BG_COUNT: bg_cnt_q <= cfg_wdata[4:0];
				REG_FG_COUNT: fg_cnt_q <= cfg_wdata[4:0];
				REG_GL_COUNT: gl_cnt_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign nb = ({4'd0, bg_cnt_q} > 9'(BG_DEPTH)) ? 9'(BG_DEPTH) : {4'd0, bg_cnt_q};
	assign nf = ({4'd0, fg_cnt_q} > 9'(FG_DEPTH)) ? 9'(FG_DEPTH) : {4'd0, fg_cnt_q};
	assign ng = (gl_cnt_q > 9'(GL_DEPTH)) ? 9'(GL_DEPTH) : gl_cnt_q;
	assign empty = (nb == '0) || (nf == '0) || (ng == '0);

	gcm_ram #(.WIDTH(COLOR_W), .DEPTH(BG_DEPTH)) u_bg_ram (
		.clk   (clk),
		.we    (accept && s_tuser == OP_LOAD_BG && {1'b0, entry_index} < 9'(BG_DEPTH)),
		.waddr (entry_index[BG_AW-1:0]),
		.wdata ({red, green, blue}),
		.raddr (b_q),
		.rdata (bg_rd)
	);

	gcm_ram #(.WIDTH(COLOR_W), .DEPTH(FG_DEPTH)) u_fg_ram (
		.clk   (clk),
		.we    (accept && s_tuser == OP_LOAD_FG && {1'b0, entry_index} < 9'(FG_DEPTH)),
		.waddr (entry_index[FG_AW-1:0]),
		.wdata ({red, green, blue}),
		.raddr (f_q),
		.rdata (fg_rd)
	);

	gcm_ram #(.WIDTH(GLYPH_W), .DEPTH(GL_DEPTH)) u_gl_ram (
		.clk   (clk),
		.we    (accept && s_tuser == OP_LOAD_GL && {1'b0, entry_index} < 9'(GL_DEPTH)),
		.waddr (entry_index[GL_AW-1:0]),
		.wdata ({lit_pixels, cell_pixels}),
		.raddr (g_q),
		.rdata (gl_rd)
	);

	assign lctl.mul   = (state_q == ST_MUL);
	assign lctl.scale = (state_q == ST_SCALE);
	assign lctl.step  = (state_q == ST_DIV);

	for (genvar c = 0; c < 3; c++) begin : g_lane
		gcm_lane u_lane (
			.clk   (clk),
			.ctl   (lctl),
			.bg_ch (bg_rd[23-8*c -: 8]),
			.fg_ch (fg_rd[23-8*c -: 8]),
			.lit   (gl_rd[23:12]),
			.total (gl_rd[11:0]),
			.y     (yv[c])
		);

		logic [Q_W-1:0] d;
		assign d = (yv[c] > {2'd0, px_q[c]}) ? yv[c] - {2'd0, px_q[c]}
		                                      : {2'd0, px_q[c]} - yv[c];
		always_ff @(posedge clk) begin
			if (state_q == ST_SQR) begin
				sq_s1[c] <= 20'(d) * 20'(d);
			end
		end
	end

	assign err = ERR_W'({1'b0, sq_s1[0]} + {1'b0, sq_s1[1]} + {1'b0, sq_s1[2]});

	assign last_g = ({1'b0, g_q} + 9'd1) == ng;
	assign last_f = ({5'd0, f_q} + 9'd1) == nf;
	assign last_b = ({5'd0, b_q} + 9'd1) == nb;
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && s_tuser == OP_MATCH) begin
					state_d = empty ? ST_FIN : ST_READ;
				end
			end
			ST_READ:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_DIV;
			ST_DIV:   state_d = (step_q == 4'(Q_W - 1)) ? ST_SQR : ST_DIV;
			ST_SQR:   state_d = ST_CMP;
			ST_CMP:   state_d = (last_g && last_f && last_b) ? ST_FIN : ST_READ;
			ST_FIN:   state_d = out_free ? ST_IDLE : ST_FIN;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q      <= '0;
			f_q      <= '0;
			g_q      <= '0;
			step_q   <= '0;
			found_q  <= 1'b0;
			best_b_q <= '0;
			best_f_q <= '0;
			best_g_q <= '0;
			best_e_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser == OP_MATCH) begin
						b_q      <= '0;
						f_q      <= '0;
						g_q      <= '0;
						found_q  <= 1'b0;
						best_b_q <= '0;
						best_f_q <= '0;
						best_g_q <= '0;
						best_e_q <= '0;
					end
				end
				ST_SCALE: step_q <= '0;
				ST_DIV:   step_q <= step_q + 4'd1;
				ST_CMP: begin
					if (!found_q || err < best_e_q) begin
						found_q  <= 1'b1;
						best_e_q <= err;
						best_b_q <= b_q;
						best_f_q <= f_q;
						best_g_q <= g_q;
					end
					if (last_g) begin
						g_q <= '0;
						if (last_f) begin
							f_q <= '0;
							if (!last_b) begin
								b_q <= b_q + BG_AW'(1);
							end
						end else begin
							f_q <= f_q + FG_AW'(1);
						end
					end else begin
						g_q <= g_q + GL_AW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tuser == OP_MATCH) begin
			px_q[0] <= red;
			px_q[1] <= green;
			px_q[2] <= blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			m_tuser <= found_q;
			m_tdata <= {3'd0, best_e_q, 8'(best_g_q), 4'(best_f_q), 4'(best_b_q)};
		end
	end

endmodule
